// ===== sv/periodic_k_nearest_select_macros.svh =====
// ----------------------------------------------------------------------------
// periodic_k_nearest_select_macros.svh
// Assertion macros shared by the block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_K_NEAREST_SELECT_MACROS_SVH
`define PERIODIC_K_NEAREST_SELECT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, idle during reset.
`define PKNS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkns assertion failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define PKNS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkns assertion failed");

`else

`define PKNS_ASSERT_IMP(lbl, ante, cons)
`define PKNS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== sv/pkns_pkg.sv =====
// ----------------------------------------------------------------------------
// pkns_pkg
// Field widths, register indexes, request codes and control structs.
// ----------------------------------------------------------------------------
package pkns_pkg;

    localparam int COORD_W    = 16;
    localparam int AGENT_W    = 10;
    localparam int BOX_W      = 16;
    localparam int NUM_W      = 11;
    localparam int NCNT_W     = 7;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = 34;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_AGENTS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 2'd2;

    localparam logic [BOX_W-1:0]  BOX_LENGTH_RST     = 16'hFFFF;
    localparam logic [NUM_W-1:0]  NUM_AGENTS_RST     = 11'd1024;
    localparam logic [NCNT_W-1:0] NEIGHBOR_COUNT_RST = 7'd4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // write the position of the request
        logic query;    // latch the query agent, read its position, clear list
        logic capture;  // capture the query position from the store
        logic issue;    // read the sweep address into the distance pipeline
        logic shift;    // drop the head of the sorted list
    } pkns_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pipe_busy;
        logic head_valid;
    } pkns_stat_t;

endpackage

// ===== sv/pkns_if.sv =====
// ----------------------------------------------------------------------------
// pkns_if
// Valid/ready channels: request, result and configuration write.
// ----------------------------------------------------------------------------
interface pkns_req_if;
    import pkns_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [AGENT_W-1:0] agent;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;

    modport source (output valid, req_type, agent, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, req_type, agent, coord_x, coord_y, coord_z, output ready);
endinterface

interface pkns_rsp_if;
    import pkns_pkg::*;

    logic               valid;
    logic               ready;
    logic [AGENT_W-1:0] neighbor;
    logic               last;

    modport source (output valid, neighbor, last, input ready);
    modport sink   (input valid, neighbor, last, output ready);
endinterface

interface pkns_cfg_if;
    import pkns_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/pkns_ram.sv =====
// ----------------------------------------------------------------------------
// pkns_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pkns_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pkns_datapath.sv =====
// ----------------------------------------------------------------------------
// pkns_datapath
// Position store, periodic distance pipeline and sorted nearest list.
// ----------------------------------------------------------------------------
module pkns_datapath #(
    parameter int MAX_AGENTS    = 1024,
    parameter int DIMS          = 2,
    parameter int MAX_NEIGHBORS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pkns_pkg::pkns_cmd_t                 cmd,
    output pkns_pkg::pkns_stat_t                stat,
    input  logic [$clog2(MAX_AGENTS)-1:0]       sweep_idx,
    input  logic [pkns_pkg::AGENT_W-1:0]        agent,
    input  logic [pkns_pkg::COORD_W-1:0]        coord_x,
    input  logic [pkns_pkg::COORD_W-1:0]        coord_y,
    input  logic [pkns_pkg::COORD_W-1:0]        coord_z,
    input  logic [pkns_pkg::BOX_W-1:0]          box_length,
    output logic [pkns_pkg::AGENT_W-1:0]        head_idx
);
    import pkns_pkg::*;

    localparam int AW = $clog2(MAX_AGENTS);
    localparam int PW = DIMS * COORD_W;

    // Position store
    logic [3*COORD_W-1:0] pos_all;
    logic [PW-1:0]        ram_rdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;

    assign pos_all   = {coord_z, coord_y, coord_x};
    assign ram_re    = cmd.query | cmd.issue;
    assign ram_raddr = cmd.issue ? sweep_idx : AW'(agent);

    pkns_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_AGENTS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (AW'(agent)),
        .wdata (pos_all[PW-1:0]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [AW-1:0] q_agent_reg;
    logic [PW-1:0] q_pos_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.query)
        begin
            q_agent_reg <= AW'(agent);
        end
        if (cmd.capture)
        begin
            q_pos_reg <= ram_rdata;
        end
    end

    // Distance pipeline: read, per-axis wrap, square, sum
    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0]       idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [COORD_W-1:0]  m_next [DIMS];
    logic [COORD_W-1:0]  m2_reg [DIMS];
    logic [SQ_W-1:0]     sq3_reg [DIMS];
    logic [DIST_W-1:0]   sum_next;
    logic [DIST_W-1:0]   dist4_reg;

    always_comb
    begin
        logic [COORD_W-1:0] ca;
        logic [COORD_W-1:0] cb;
        logic [COORD_W-1:0] ad;
        logic [COORD_W-1:0] alt;
        for (int d = 0; d < DIMS; d++)
        begin
            ca        = q_pos_reg[d*COORD_W +: COORD_W];
            cb        = ram_rdata[d*COORD_W +: COORD_W];
            ad        = (ca > cb) ? (ca - cb) : (cb - ca);
            alt       = (ad > box_length) ? (ad - box_length) : (box_length - ad);
            m_next[d] = (alt < ad) ? alt : ad;
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int d = 0; d < DIMS; d++)
        begin
            sum_next = sum_next + DIST_W'(sq3_reg[d]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue && (sweep_idx != q_agent_reg);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= sweep_idx;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        for (int d = 0; d < DIMS; d++)
        begin
            m2_reg[d]  <= m_next[d];
            sq3_reg[d] <= SQ_W'(m2_reg[d]) * SQ_W'(m2_reg[d]);
        end
        dist4_reg <= sum_next;
    end

    // Sorted list, ascending distance; an equal distance goes behind the
    // entries already held, which keeps the lower index first.
    logic              lst_vld_reg  [MAX_NEIGHBORS];
    logic [DIST_W-1:0] lst_dist_reg [MAX_NEIGHBORS];
    logic [AW-1:0]     lst_idx_reg  [MAX_NEIGHBORS];
    logic              lst_vld_next  [MAX_NEIGHBORS];
    logic [DIST_W-1:0] lst_dist_next [MAX_NEIGHBORS];
    logic [AW-1:0]     lst_idx_next  [MAX_NEIGHBORS];
    logic              lt      [MAX_NEIGHBORS];
    logic              prev_lt [MAX_NEIGHBORS];

    always_comb
    begin
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            lt[j] = !lst_vld_reg[j] || (dist4_reg < lst_dist_reg[j]);
        end
        prev_lt[0] = 1'b0;
        for (int j = 1; j < MAX_NEIGHBORS; j++)
        begin
            prev_lt[j] = lt[j-1];
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            lst_vld_next[j]  = lst_vld_reg[j];
            lst_dist_next[j] = lst_dist_reg[j];
            lst_idx_next[j]  = lst_idx_reg[j];
        end
        if (v4_reg)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                if (lt[j] && !prev_lt[j])
                begin
                    lst_vld_next[j]  = 1'b1;
                    lst_dist_next[j] = dist4_reg;
                    lst_idx_next[j]  = idx4_reg;
                end
                else if (lt[j])
                begin
                    lst_vld_next[j]  = lst_vld_reg[j-1];
                    lst_dist_next[j] = lst_dist_reg[j-1];
                    lst_idx_next[j]  = lst_idx_reg[j-1];
                end
            end
        end
        else if (cmd.shift)
        begin
            for (int j = 0; j < MAX_NEIGHBORS - 1; j++)
            begin
                lst_vld_next[j]  = lst_vld_reg[j+1];
                lst_dist_next[j] = lst_dist_reg[j+1];
                lst_idx_next[j]  = lst_idx_reg[j+1];
            end
            lst_vld_next[MAX_NEIGHBORS-1] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                lst_vld_reg[j] <= 1'b0;
            end
        end
        else if (cmd.query)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                lst_vld_reg[j] <= 1'b0;
            end
        end
        else
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                lst_vld_reg[j] <= lst_vld_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            lst_dist_reg[j] <= lst_dist_next[j];
            lst_idx_reg[j]  <= lst_idx_next[j];
        end
    end

    assign stat.pipe_busy  = v1_reg | v2_reg | v3_reg | v4_reg;
    assign stat.head_valid = lst_vld_reg[0];
    assign head_idx        = AGENT_W'(lst_idx_reg[0]);

endmodule

// ===== sv/pkns_ctrl.sv =====
// ----------------------------------------------------------------------------
// pkns_ctrl
// Request sequencer: load, query capture, sweep, drain and result emit.
// ----------------------------------------------------------------------------
module pkns_ctrl #(
    parameter int MAX_AGENTS    = 1024,
    parameter int MAX_NEIGHBORS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              req_type,
    input  logic [pkns_pkg::AGENT_W-1:0]      agent,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic                              rsp_last,
    input  logic [pkns_pkg::NUM_W-1:0]        num_agents,
    input  logic [pkns_pkg::NCNT_W-1:0]       neighbor_count,
    output pkns_pkg::pkns_cmd_t               cmd,
    input  pkns_pkg::pkns_stat_t              stat,
    output logic [$clog2(MAX_AGENTS)-1:0]     sweep_idx
);
    import pkns_pkg::*;

    localparam int AW = $clog2(MAX_AGENTS);
    localparam int CW = $clog2(MAX_AGENTS + 1);
    localparam int KW = $clog2(MAX_NEIGHBORS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CAPT  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] left_reg, left_next;
    logic [CW-1:0] n_eff;
    logic [KW-1:0] k_eff;
    logic          accept;
    logic          q_ok;

    assign n_eff = (32'(num_agents) < MAX_AGENTS) ? CW'(num_agents) : CW'(MAX_AGENTS);

    // Clamp to the agents other than the query, and to the list depth
    always_comb
    begin
        int kn;
        kn = int'(neighbor_count);
        if (kn > int'(n_eff) - 1)
        begin
            kn = int'(n_eff) - 1;
        end
        if (kn > MAX_NEIGHBORS)
        begin
            kn = MAX_NEIGHBORS;
        end
        if (kn < 0)
        begin
            kn = 0;
        end
        k_eff = KW'(kn);
    end

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid & req_ready;
    assign q_ok      = (32'(agent) < 32'(n_eff)) && (k_eff != '0);

    assign rsp_valid = (state_reg == S_EMIT);
    assign rsp_last  = (left_reg == KW'(1));
    assign sweep_idx = cnt_reg[AW-1:0];

    assign cmd.load    = accept && (req_type == REQ_LOAD) && (32'(agent) < MAX_AGENTS);
    assign cmd.query   = accept && (req_type == REQ_QUERY);
    assign cmd.capture = (state_reg == S_CAPT);
    assign cmd.issue   = (state_reg == S_SWEEP);
    assign cmd.shift   = rsp_valid && rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.query && q_ok)
                begin
                    left_next  = k_eff;
                    state_next = S_CAPT;
                end
            end
            S_CAPT:
            begin
                cnt_next   = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (cnt_reg == n_eff - CW'(1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (rsp_ready)
                begin
                    left_next = left_reg - KW'(1);
                    if (rsp_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ===== sv/periodic_k_nearest_select.sv =====
// ----------------------------------------------------------------------------
// periodic_k_nearest_select
// k nearest neighbors of a stored agent in a periodic box.
// ----------------------------------------------------------------------------
// A load request (req_type 0) writes one agent position into the store and
// leaves the block ready for another request. A query request (req_type 1)
// names an agent; the block reads the query position, then walks agents 0
// to n-1 through the position store one per cycle, where n is num_agents
// capped at MAX_AGENTS, forms the squared periodic distance
// min(|d|, |L-|d||)^2 summed over the axes, and inserts each candidate into a
// sorted register list. It then returns the neighbor_count nearest agents,
// nearest first, lower index first on equal distance, with last set on the
// final one; the query agent is never returned and the count is capped at n-1
// and at MAX_NEIGHBORS. A query holds the block from its acceptance until the
// next request can be accepted: the block captures the query position, sweeps
// the store (one read of the store per cycle), drains the distance pipeline
// and presents the results at the output, one at a time, each held until
// taken. A query on an agent not below n, or one with a count of zero,
// returns no results and leaves the block ready for another request.
// Positions that were never loaded read as undefined. Write the
// configuration only while no request is in flight.
// ----------------------------------------------------------------------------
`include "periodic_k_nearest_select_macros.svh"

module periodic_k_nearest_select #(
    parameter int MAX_AGENTS    = 1024,
    parameter int DIMS          = 2,
    parameter int MAX_NEIGHBORS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    pkns_cfg_if.sink    cfg,
    pkns_req_if.sink    req,
    pkns_rsp_if.source  rsp
);
    import pkns_pkg::*;

    localparam int AW = $clog2(MAX_AGENTS);

    // Configuration registers, always ready; unknown indexes
    // drop silently.
    logic [BOX_W-1:0]  box_length_reg;
    logic [NUM_W-1:0]  num_agents_reg;
    logic [NCNT_W-1:0] neighbor_count_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_length_reg     <= BOX_LENGTH_RST;
            num_agents_reg     <= NUM_AGENTS_RST;
            neighbor_count_reg <= NEIGHBOR_COUNT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_BOX_LENGTH:     box_length_reg     <= cfg.data[BOX_W-1:0];
                REG_NUM_AGENTS:     num_agents_reg     <= cfg.data[NUM_W-1:0];
                REG_NEIGHBOR_COUNT: neighbor_count_reg <= cfg.data[NCNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Controller and datapath talk only through these
    pkns_cmd_t     cmd;
    pkns_stat_t    stat;
    logic [AW-1:0] sweep_idx;

    pkns_ctrl #(
        .MAX_AGENTS    (MAX_AGENTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req.valid),
        .req_ready      (req.ready),
        .req_type       (req.req_type),
        .agent          (req.agent),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_last       (rsp.last),
        .num_agents     (num_agents_reg),
        .neighbor_count (neighbor_count_reg),
        .cmd            (cmd),
        .stat           (stat),
        .sweep_idx      (sweep_idx)
    );

    pkns_datapath #(
        .MAX_AGENTS    (MAX_AGENTS),
        .DIMS          (DIMS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .sweep_idx  (sweep_idx),
        .agent      (req.agent),
        .coord_x    (req.coord_x),
        .coord_y    (req.coord_y),
        .coord_z    (req.coord_z),
        .box_length (box_length_reg),
        .head_idx   (rsp.neighbor)
    );

    // No new request while results are still going out
    `PKNS_ASSERT_IMP(a_no_req_while_emit, rsp.valid, !req.ready)
    // Every presented result sits at the head of a filled list
    `PKNS_ASSERT_IMP(a_head_filled, rsp.valid, stat.head_valid)
    // The final result closes the query
    `PKNS_ASSERT_NXT(a_last_closes, (rsp.valid && rsp.ready && rsp.last), !rsp.valid)
    // A load leaves the block ready for a request in the next cycle
    `PKNS_ASSERT_NXT(a_load_one_cycle, (req.valid && req.ready && req.req_type == REQ_LOAD), req.ready)

endmodule

// ===== verif/periodic_k_nearest_select_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_k_nearest_select_test
// Self-checking bench for the periodic k-nearest-neighbor selector.
// ----------------------------------------------------------------------------
// Load and query requests go in over the request channel. Every accepted
// request goes through a local copy of the position store at the moment it is
// accepted. Each query queues the neighbor picks it should produce. A monitor
// pops one pick for every accepted result and compares both fields.
// Configuration is written only once the block has gone quiet. The run covers
// the reset box length and neighbor count over a short store, hand-placed
// wrap and tie cases, count saturation, an empty box, a full neighbor list,
// and random phases with random settings. Random stalls on both channels stop
// for the last stretch.
// ----------------------------------------------------------------------------
module periodic_k_nearest_select_test;
    import pkns_pkg::*;

    localparam int MAX_AGENTS     = 1024;
    localparam int DIMS           = 2;
    localparam int MAX_NEIGHBORS  = 64;
    localparam int TOTAL_ITEMS    = 480;
    localparam int CALM_ITEMS     = 400;   // random stalls stop after this many
    localparam int RESET_AGENTS   = 32;    // store size used under reset settings
    localparam int WIDE_AGENTS    = 100;   // store size for the full neighbor list
    localparam int STALL_LIMIT    = 20000; // cycles without any handshake
    localparam int PRINT_LIMIT    = 200;

    typedef struct packed {
        logic [AGENT_W-1:0] neighbor;
        logic               last;
    } neighbor_pick_t;

    logic clk;
    logic rst_n;

    pkns_req_if req_ch ();
    pkns_rsp_if rsp_ch ();
    pkns_cfg_if cfg_ch ();

    periodic_k_nearest_select #(
        .MAX_AGENTS    (MAX_AGENTS),
        .DIMS          (DIMS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Local copy of the register file, reset values from the package
    logic [BOX_W-1:0]  box_length_q     = BOX_LENGTH_RST;
    logic [NUM_W-1:0]  num_agents_q     = NUM_AGENTS_RST;
    logic [NCNT_W-1:0] neighbor_count_q = NEIGHBOR_COUNT_RST;

    // Local copy of the position store: x low, y middle, z high
    logic [3*COORD_W-1:0] agent_pos [MAX_AGENTS];
    bit                   agent_loaded [MAX_AGENTS];

    // Scratch for the selection sweep of one query
    logic [DIST_W-1:0] sweep_dist [MAX_AGENTS];
    bit                sweep_taken [MAX_AGENTS];

    neighbor_pick_t expected_picks [$];

    int  mismatch_count = 0;
    int  sent_items     = 0;
    bit  idle_on        = 1'b1;
    int  rsp_stall_left = 0;
    int  quiet_cycles   = 0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int active_agents();
        return (num_agents_q > MAX_AGENTS) ? MAX_AGENTS : int'(num_agents_q);
    endfunction

    // Worst-case time the block may still be busy on a request that has
    // produced nothing visible: a full sweep, the drain and the output.
    function automatic int busy_cycles();
        return active_agents() + MAX_NEIGHBORS + 16;
    endfunction

    // Squared separation using the nearest periodic image on each axis
    function automatic logic [DIST_W-1:0] periodic_sq_dist(input int a, input int b);
        logic [COORD_W-1:0] ca;
        logic [COORD_W-1:0] cb;
        logic [COORD_W-1:0] ad;
        logic [COORD_W-1:0] alt;
        logic [DIST_W-1:0]  m;
        logic [DIST_W-1:0]  sum;
        int                 d;
        sum = '0;
        for (d = 0; d < DIMS && d < 3; d++)
        begin
            ca  = agent_pos[a][COORD_W*d +: COORD_W];
            cb  = agent_pos[b][COORD_W*d +: COORD_W];
            ad  = (ca > cb) ? ca - cb : cb - ca;
            alt = (ad > box_length_q) ? ad - box_length_q : box_length_q - ad;
            m   = DIST_W'((alt < ad) ? alt : ad);
            sum = sum + m * m;
        end
        return sum;
    endfunction

    // Queue the picks of one query: nearest first, lower index on a tie
    function automatic void predict_neighbors(input logic [AGENT_W-1:0] who);
        int             n;
        int             k;
        int             r;
        int             i;
        int             best;
        neighbor_pick_t pick;
        n = active_agents();
        if (int'(who) >= n)
            return;
        k = int'(neighbor_count_q);
        if (k > n - 1)
            k = n - 1;
        if (k > MAX_NEIGHBORS)
            k = MAX_NEIGHBORS;
        for (i = 0; i < n; i++)
        begin
            sweep_taken[i] = (i == int'(who));
            if (i != int'(who))
                sweep_dist[i] = periodic_sq_dist(int'(who), i);
        end
        for (r = 0; r < k; r++)
        begin
            best = -1;
            for (i = 0; i < n; i++)
                if (!sweep_taken[i] && (best < 0 || sweep_dist[i] < sweep_dist[best]))
                    best = i;
            if (best < 0)
                return;
            sweep_taken[best] = 1'b1;
            pick.neighbor     = best[AGENT_W-1:0];
            pick.last         = (r == k - 1);
            expected_picks.push_back(pick);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Compare every accepted result with the oldest pending pick
    always @(posedge clk)
    begin
        neighbor_pick_t want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_picks.size() == 0)
                report_mismatch($sformatf("unexpected result neighbor=%0d last=%0b",
                                          rsp_ch.neighbor, rsp_ch.last));
            else
            begin
                want = expected_picks.pop_front();
                if (rsp_ch.neighbor !== want.neighbor)
                    report_mismatch($sformatf("neighbor %0d, wanted %0d",
                                              rsp_ch.neighbor, want.neighbor));
                if (rsp_ch.last !== want.last)
                    report_mismatch($sformatf("last %0b on neighbor %0d, wanted %0b",
                                              rsp_ch.last, want.neighbor, want.last));
            end
        end
    end

    // Stall the result channel in random bursts while idling is on
    always @(negedge clk)
    begin
        if (rsp_stall_left > 0)
        begin
            rsp_stall_left = rsp_stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rsp_stall_left = $urandom_range(1, 17) - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Abort when no channel has moved anything for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request and register drivers
    // ------------------------------------------------------------------------
    // Drive one request at a falling edge, hold it until accepted, then
    // advance the local store or queue the picks of the query.
    task automatic send_request(input logic kind, input logic [AGENT_W-1:0] who,
                                input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y,
                                input logic [COORD_W-1:0] z);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.agent    <= who;
        req_ch.coord_x  <= x;
        req_ch.coord_y  <= y;
        req_ch.coord_z  <= z;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        sent_items++;
        if (kind == REQ_LOAD)
        begin
            agent_pos[who]    = {z, y, x};
            agent_loaded[who] = 1'b1;
        end
        else
            predict_neighbors(who);
    endtask

    // Pick a coordinate: mostly inside the box, sometimes at the extremes,
    // sometimes from a small grid so that equal distances show up.
    function automatic logic [COORD_W-1:0] pick_coord();
        int span;
        span = (box_length_q == 0) ? 65536 : int'(box_length_q);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return COORD_W'($urandom_range(0, 3) * 8);
            4:       return COORD_W'($urandom_range(0, 65535));
            default: return COORD_W'($urandom_range(0, span - 1));
        endcase
    endfunction

    task automatic load_agent(input int who, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
        send_request(REQ_LOAD, who[AGENT_W-1:0], x, y, z);
    endtask

    task automatic load_random(input int who);
        load_agent(who, pick_coord(), pick_coord(), pick_coord());
    endtask

    // Query coordinates are ignored by the block; randomize them anyway
    task automatic query_agent(input int who);
        send_request(REQ_QUERY, who[AGENT_W-1:0], COORD_W'($urandom_range(0, 65535)),
                     COORD_W'($urandom_range(0, 65535)), COORD_W'($urandom_range(0, 65535)));
    endtask

    // Fill every slot in use that was never loaded, so no query reads one
    task automatic load_missing();
        int i;
        for (i = 0; i < active_agents(); i++)
            if (!agent_loaded[i])
                load_random(i);
    endtask

    // Drop the request, wait for all picks, then hold off for requests that
    // produce nothing but may still occupy the block.
    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (busy_cycles()) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_BOX_LENGTH:     box_length_q     = value[BOX_W-1:0];
            REG_NUM_AGENTS:     num_agents_q     = value[NUM_W-1:0];
            REG_NEIGHBOR_COUNT: neighbor_count_q = value[NCNT_W-1:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input int box, input int num, input int count);
        settle();
        write_register(REG_BOX_LENGTH, CFG_DATA_W'(box));
        write_register(REG_NUM_AGENTS, CFG_DATA_W'(num));
        write_register(REG_NEIGHBOR_COUNT, CFG_DATA_W'(count));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset box length and neighbor count over a short store
    task automatic test_reset_defaults();
        int i;
        write_register(REG_NUM_AGENTS, CFG_DATA_W'(RESET_AGENTS));
        for (i = 0; i < RESET_AGENTS; i++)
            load_random(i);
        query_agent(0);
        query_agent(RESET_AGENTS - 1);
        query_agent($urandom_range(1, RESET_AGENTS - 2));
    endtask

    // Hand-placed agents in a box of 100: wrap across an edge, equal
    // distances, coordinates far outside the box, queries out of range.
    task automatic test_periodic_wrap();
        configure(100, 8, 3);
        load_agent(0, 0, 0, 16'hFFFF);
        load_agent(1, 99, 0, 0);            // one step away through the edge
        load_agent(2, 50, 50, 0);
        load_agent(3, 0, 0, 0);             // same spot as agent 0
        load_agent(4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        load_agent(5, 1, 1, 0);
        load_agent(6, 0, 99, 0);            // ties with agent 1 from agent 0
        load_agent(7, 200, 0, 0);           // two boxes away on x
        load_agent(MAX_AGENTS - 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        query_agent(0);
        query_agent(3);
        query_agent(7);
        query_agent(4);
        query_agent(8);                     // first index not in use
        query_agent(MAX_AGENTS - 1);
    endtask

    // Neighbor count saturation, an empty box, one agent and none in use
    task automatic test_count_limits();
        configure(0, 8, 16'hFFFF);          // count saturates at n-1
        query_agent(0);
        query_agent(4);
        configure(1, 1, 1);                 // only the query agent is in use
        query_agent(0);
        query_agent(5);
        configure(65535, 0, 0);             // nothing in use
        query_agent(0);
        configure(65535, 8, 0);             // zero count returns nothing
        query_agent(2);
        configure(65535, 2, 1);
        query_agent(1);
    endtask

    // Count register beyond the list depth: a full neighbor list
    task automatic test_full_store();
        configure($urandom_range(1, 65535), WIDE_AGENTS, 16'hFFFF);
        load_missing();
        query_agent($urandom_range(0, WIDE_AGENTS - 1));
        query_agent(WIDE_AGENTS - 1);
    endtask

    // Random settings per phase, then a mix of queries and reloads with a
    // few queries out of range, until the item budget is spent.
    task automatic test_random_traffic();
        int box;
        int num;
        int count;
        int n;
        int len;
        int j;
        int pick;
        while (sent_items < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       box = 0;
                1:       box = 1;
                2:       box = 65535;
                3:       box = $urandom_range(2, 255);
                default: box = $urandom_range(256, 65534);
            endcase
            case ($urandom_range(0, 19))
                0:       num = 0;
                1:       num = 1;
                2:       num = 64;
                3:       num = WIDE_AGENTS;
                default: num = $urandom_range(2, 24);
            endcase
            case ($urandom_range(0, 7))
                0:       count = 0;
                1:       count = 127;
                2:       count = 64;
                3:       count = (num > 0) ? num - 1 : 0;
                default: count = $urandom_range(1, 8);
            endcase
            configure(box, num, count);
            load_missing();
            n   = active_agents();
            len = (n > 64) ? $urandom_range(3, 6) : $urandom_range(15, 40);
            for (j = 0; j < len; j++)
            begin
                if (sent_items >= CALM_ITEMS)
                    idle_on = 1'b0;
                pick = $urandom_range(0, 19);
                if (pick < 11 && n > 0)
                    query_agent($urandom_range(0, n - 1));
                else if (pick < 16 && n > 0)
                    load_random($urandom_range(0, n - 1));
                else if (pick < 18 || n >= MAX_AGENTS)
                    load_random($urandom_range(0, MAX_AGENTS - 1));
                else
                    query_agent($urandom_range(n, MAX_AGENTS - 1));
            end
        end
    endtask

    // Wait out every pick and the tail of the last request, then decide
    task automatic finish_run();
        settle();
        while (expected_picks.size() != 0)
        begin
            report_mismatch($sformatf("missing result, wanted neighbor %0d",
                                      expected_picks[0].neighbor));
            void'(expected_picks.pop_front());
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.agent    = '0;
        req_ch.coord_x  = '0;
        req_ch.coord_y  = '0;
        req_ch.coord_z  = '0;
        rsp_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_BOX_LENGTH;
        cfg_ch.data     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_periodic_wrap();
        test_count_limits();
        test_full_store();
        test_random_traffic();
        finish_run();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
